[hw/rtl/cd_section_frame_aligner_top_assert.svh]
// Assertion macros for the CD section frame aligner.
// Used by the top level; relies on clk and rst being in scope.
`ifndef CD_SECTION_FRAME_ALIGNER_TOP_ASSERT_SVH
`define CD_SECTION_FRAME_ALIGNER_TOP_ASSERT_SVH

// same-cycle implication
`define CDSFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdsfa assertion failed");

// next-cycle implication
`define CDSFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdsfa assertion failed");

`endif

[hw/rtl/cdsfa_pkg.sv]
// Shared constants and types for the CD section frame aligner.
// No dependencies.
`default_nettype none

package cdsfa_pkg;

  localparam int unsigned SECTION_FRAMES = 98;
  localparam int unsigned SLOT_W         = 7;

  localparam logic [1:0] KIND_SYNC0 = 2'd0;
  localparam logic [1:0] KIND_SYNC1 = 2'd1;
  localparam logic [1:0] KIND_SUB   = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [1:0] PH_SYNC0 = 2'd0;
  localparam logic [1:0] PH_SYNC1 = 2'd1;
  localparam logic [1:0] PH_SUB   = 2'd2;

  typedef struct packed {
    logic [31:0] error_flags;
    logic [63:0] data_3;
    logic [63:0] data_2;
    logic [63:0] data_1;
    logic [63:0] data_0;
    logic [7:0]  subcode_byte;
  } frame_t;

  // decision taken for one accepted item
  typedef struct packed {
    logic              two;        // blank sync0 goes out first
    logic              zero_byte;
    logic [SLOT_W-1:0] slot;
    logic              drop;
    logic              last;
  } dec_t;

  typedef struct packed {
    frame_t            frame;
    logic [SLOT_W-1:0] slot;
    logic              drop;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/cd_section_frame_aligner_top.sv]
// An accepted item passes the input stage, then the result register, to m_tvalid.
// Throughput: one item per cycle unless m_tready stalls; a sync1 seen while
// sync0 is expected issues a blank sync0, then the frame, holding the input stage.
// Reset (rst, synchronous): empties both stages and returns to expecting sync0.
// Top level: input stage, result register and stream ports.
// Depends on cdsfa_pkg, cdsfa_ctrl and cd_section_frame_aligner_top_assert.svh.
`default_nettype none

`include "cd_section_frame_aligner_top_assert.svh"

module cd_section_frame_aligner_top
  import cdsfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // subcode_byte[7:0], data_0[71:8], data_1[135:72], data_2[199:136],
  // data_3[263:200], error_flags[295:264]
  input  wire logic [295:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // data_0[63:0], data_1[127:64], data_2[191:128], data_3[255:192],
  // error_flags[287:256], subcode_byte[295:288], slot[302:296], zero[303]
  output logic [303:0]      m_tdata,
  // drop_partial[0]
  output logic [0:0]        m_tuser,
  // section_last
  output logic              m_tlast
);

  dec_t    dec;
  logic    in_acc;
  logic    a_valid, a_half;
  frame_t  a_frame;
  dec_t    a_dec;
  logic    o_valid;
  result_t o_res;
  logic    o_load, a_issue, a_free;
  result_t issue_res;

  assign in_acc = s_tvalid && s_tready;

  cdsfa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (in_acc),
    .kind   (s_tuser),
    .dec    (dec)
  );

  assign o_load   = !o_valid || m_tready;
  assign a_issue  = a_valid && o_load;
  assign a_free   = a_issue && (!a_dec.two || a_half);
  assign s_tready = !a_valid || a_free;

  always_comb begin
    issue_res       = '0;
    if (a_dec.two && !a_half) begin
      // blank sync0 at slot zero, everything else zero
      issue_res = '0;
    end else begin
      issue_res.frame = a_frame;
      if (a_dec.zero_byte) begin
        issue_res.frame.subcode_byte = '0;
      end
      issue_res.slot = a_dec.slot;
      issue_res.drop = a_dec.drop;
      issue_res.last = a_dec.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_half  <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid <= 1'b1;
        a_half  <= 1'b0;
      end else if (a_free) begin
        a_valid <= 1'b0;
        a_half  <= 1'b0;
      end else if (a_issue) begin
        a_half  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_frame <= frame_t'(s_tdata);
      a_dec   <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_issue) begin
      o_res <= issue_res;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_res.slot, o_res.frame.subcode_byte, o_res.frame.error_flags,
                     o_res.frame.data_3, o_res.frame.data_2, o_res.frame.data_1,
                     o_res.frame.data_0};
  assign m_tuser  = o_res.drop;
  assign m_tlast  = o_res.last;

  `CDSFA_ASSERT_NEXT(a_blank_first, a_issue && a_dec.two && !a_half,
                     o_valid && o_res.slot == '0 && o_res.frame == '0 && !o_res.drop)
  `CDSFA_ASSERT_NOW(a_last_slot, m_tvalid && m_tlast,
                    o_res.slot == SLOT_W'(SECTION_FRAMES - 1))
  `CDSFA_ASSERT_NOW(a_drop_slot, m_tvalid && m_tuser[0], o_res.slot == '0 && !o_res.last)

endmodule

`default_nettype wire

[hw/rtl/cdsfa_ctrl.sv]
// Section phase tracker: holds phase and fill count, labels each item.
// Depends on cdsfa_pkg.
`default_nettype none

module cdsfa_ctrl
  import cdsfa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [1:0] kind,
  output dec_t            dec
);

  logic [1:0]        phase, phase_next;
  logic [SLOT_W-1:0] fill_count, fill_count_next;
  logic [1:0]        k;
  logic [SLOT_W:0]   fill_inc;
  logic              full;

  always_comb begin
    k        = (kind == KIND_RSVD) ? KIND_SUB : kind;
    fill_inc = {1'b0, fill_count} + 1'b1;
    full     = fill_inc >= (SLOT_W+1)'(SECTION_FRAMES);
  end

  always_comb begin
    dec             = '0;
    phase_next      = phase;
    fill_count_next = fill_count;
    unique case (phase)
      PH_SYNC1: begin
        if (k == KIND_SYNC0) begin
          dec.drop        = 1'b1;
          fill_count_next = SLOT_W'(1);
          phase_next      = PH_SYNC1;
        end else begin
          dec.slot        = SLOT_W'(1);
          dec.zero_byte   = (k == KIND_SUB);
          fill_count_next = SLOT_W'(2);
          phase_next      = PH_SUB;
        end
      end
      PH_SUB: begin
        if (k == KIND_SYNC0) begin
          // restart: partial section is thrown away downstream
          dec.drop        = 1'b1;
          fill_count_next = SLOT_W'(1);
          phase_next      = PH_SYNC1;
        end else begin
          dec.slot      = fill_count;
          dec.zero_byte = (k == KIND_SYNC1);
          dec.last      = full;
          if (full) begin
            fill_count_next = '0;
            phase_next      = PH_SYNC0;
          end else begin
            fill_count_next = fill_inc[SLOT_W-1:0];
          end
        end
      end
      default: begin
        if (k == KIND_SYNC1) begin
          dec.two         = 1'b1;
          dec.slot        = SLOT_W'(1);
          fill_count_next = SLOT_W'(2);
          phase_next      = PH_SUB;
        end else begin
          dec.zero_byte   = (k == KIND_SUB);
          fill_count_next = SLOT_W'(1);
          phase_next      = PH_SYNC1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC0;
      fill_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      fill_count <= fill_count_next;
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for cd_section_frame_aligner_top: opening table of frames, then random
// frame streams with idle bursts on both stream ports, checked against an in-bench predictor.
// Depends on cdsfa_pkg and the RTL of the section frame aligner.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdsfa_pkg::*;

  localparam int N_RANDOM = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [6:0] SLOT_SYNC0 = 7'd0;
  localparam logic [6:0] SLOT_SYNC1 = 7'd1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       sub_byte;
    logic [3:0][63:0] data;
    logic [31:0]      flags;
  } f3_item_t;

  typedef struct packed {
    logic [3:0][63:0] data;
    logic [31:0]      flags;
    logic [7:0]       sub_byte;
    logic [6:0]       slot;
    logic             drop;
    logic             last;
  } aligned_frame_t;

  typedef struct {
    f3_item_t   it;
    bit         typed;
    logic [7:0] e_byte;
    logic [6:0] e_slot;
    logic       e_drop;
  } opening_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [295:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [303:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;

  aligned_frame_t pending_frames[$];
  opening_row_t   opening_frames[$];
  logic [1:0]     ph = PH_SYNC0;
  logic [6:0]     fill = '0;
  int             fail_count = 0;
  int             cycles = 0;
  bit             idle_en = 1'b1;

  cd_section_frame_aligner_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Work out where a frame lands in the section and queue the frames it emits.
  function automatic void place_frame(input f3_item_t it);
    logic [1:0]     k;
    aligned_frame_t fr;
    k = (it.kind == KIND_RSVD) ? KIND_SUB : it.kind;
    fr.data = it.data;
    fr.flags = it.flags;
    fr.sub_byte = it.sub_byte;
    fr.slot = SLOT_SYNC0;
    fr.drop = 1'b0;
    fr.last = 1'b0;
    case (ph)
      PH_SYNC1: begin
        if (k == KIND_SYNC0) begin
          fr.drop = 1'b1;
          fill = 7'd1;
        end else begin
          if (k == KIND_SUB) fr.sub_byte = '0;
          fr.slot = SLOT_SYNC1;
          fill = 7'd2;
          ph = PH_SUB;
        end
      end
      PH_SUB: begin
        if (k == KIND_SYNC0) begin
          fr.drop = 1'b1;
          fill = 7'd1;
          ph = PH_SYNC1;
        end else begin
          if (k == KIND_SYNC1) fr.sub_byte = '0;
          fr.slot = fill;
          fr.last = (fill + 7'd1) >= SECTION_FRAMES;
          if (fr.last) begin
            fill = '0;
            ph = PH_SYNC0;
          end else begin
            fill = fill + 7'd1;
          end
        end
      end
      default: begin
        if (k == KIND_SYNC1) begin
          // blank sync0 goes out ahead of the frame
          pending_frames.push_back('0);
          fr.slot = SLOT_SYNC1;
          fill = 7'd2;
          ph = PH_SUB;
        end else begin
          if (k == KIND_SUB) fr.sub_byte = '0;
          fill = 7'd1;
          ph = PH_SYNC1;
        end
      end
    endcase
    pending_frames.push_back(fr);
  endfunction

  function automatic logic [1:0] pick_kind(input int err_pct);
    int r;
    r = $urandom_range(0, 19);
    if (ph != PH_SUB && ph != PH_SYNC1) begin
      if (r < 8) return KIND_SYNC0;
      if (r < 13) return KIND_SYNC1;
      if (r < 17) return KIND_SUB;
      return KIND_RSVD;
    end
    if ($urandom_range(0, 99) < err_pct) return 2'($urandom_range(0, 3));
    if (ph == PH_SYNC1) return KIND_SYNC1;
    return (r == 0) ? KIND_RSVD : KIND_SUB;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [7:0] b,
                                  input logic [63:0] w, input bit typed,
                                  input logic [7:0] e_byte, input logic [6:0] e_slot,
                                  input logic e_drop);
    opening_row_t r;
    r.it.kind = kind;
    r.it.sub_byte = b;
    r.it.data = {4{w}};
    r.it.flags = w[63:32];
    r.typed = typed;
    r.e_byte = e_byte;
    r.e_slot = e_slot;
    r.e_drop = e_drop;
    opening_frames.push_back(r);
  endfunction

  task automatic send_item(input f3_item_t it);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {it.flags, it.data[3], it.data[2], it.data[1], it.data[0], it.sub_byte};
    s_tuser <= it.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Hold off the result port in bursts while idling is on.
  initial begin
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    aligned_frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("result with no expectation waiting: slot %0d", m_tdata[302:296]);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        check_field("out_data_0", want.data[0], m_tdata[63:0]);
        check_field("out_data_1", want.data[1], m_tdata[127:64]);
        check_field("out_data_2", want.data[2], m_tdata[191:128]);
        check_field("out_data_3", want.data[3], m_tdata[255:192]);
        check_field("out_error_flags", 64'(want.flags), 64'(m_tdata[287:256]));
        check_field("out_subcode_byte", 64'(want.sub_byte), 64'(m_tdata[295:288]));
        check_field("slot", 64'(want.slot), 64'(m_tdata[302:296]));
        check_field("tdata padding", 64'd0, 64'(m_tdata[303]));
        check_field("drop_partial", 64'(want.drop), 64'(m_tuser[0]));
        check_field("section_last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    f3_item_t       it;
    aligned_frame_t typed;
    int             err_pct;
    err_pct = 0;

    add_row(KIND_SYNC1, 8'hFF, '1, 1'b0, '0, '0, 1'b0);
    add_row(KIND_SUB, 8'h00, '0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_SYNC1, 8'h5A, 64'h0123_4567_89AB_CDEF, 1'b1, 8'h00, 7'd3, 1'b0);
    add_row(KIND_RSVD, 8'h3C, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0, '0, '0, 1'b0);
    add_row(KIND_SYNC0, 8'h81, '1, 1'b1, 8'h81, SLOT_SYNC0, 1'b1);
    add_row(KIND_SYNC0, 8'h7E, 64'h5A5A_5A5A_A5A5_A5A5, 1'b1, 8'h7E, SLOT_SYNC0, 1'b1);
    add_row(KIND_SUB, 8'hA5, '0, 1'b1, 8'h00, SLOT_SYNC1, 1'b0);
    add_row(KIND_SUB, 8'hFF, '1, 1'b0, '0, '0, 1'b0);
    add_row(KIND_SYNC0, 8'h00, '0, 1'b1, 8'h00, SLOT_SYNC0, 1'b1);
    add_row(KIND_SYNC1, 8'hC3, 64'hFEDC_BA98_7654_3210, 1'b1, 8'hC3, SLOT_SYNC1, 1'b0);
    add_row(KIND_SYNC0, 8'h18, '1, 1'b1, 8'h18, SLOT_SYNC0, 1'b1);
    add_row(KIND_RSVD, 8'h99, 64'h8000_0001_8000_0001, 1'b0, '0, '0, 1'b0);
    add_row(KIND_SUB, 8'h11, 64'h7FFF_FFFE_7FFF_FFFE, 1'b0, '0, '0, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_frames[i]) begin
      place_frame(opening_frames[i].it);
      if (opening_frames[i].typed) begin
        void'(pending_frames.pop_back());
        typed.data = opening_frames[i].it.data;
        typed.flags = opening_frames[i].it.flags;
        typed.sub_byte = opening_frames[i].e_byte;
        typed.slot = opening_frames[i].e_slot;
        typed.drop = opening_frames[i].e_drop;
        typed.last = 1'b0;
        pending_frames.push_back(typed);
      end
      send_item(opening_frames[i].it);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // quiet stretches now and then, and none over the tail of the run
      idle_en = (n < N_RANDOM - 300) && ((n / 200) % 4 != 3);
      if (n % 50 == 0) begin
        case ($urandom_range(0, 4))
          0, 1: err_pct = 0;
          2: err_pct = 1;
          3: err_pct = 3;
          default: err_pct = 15;
        endcase
      end
      it.kind = pick_kind(err_pct);
      it.sub_byte = 8'($urandom_range(0, 255));
      for (int w = 0; w < 4; w++) it.data[w] = {$urandom, $urandom};
      it.flags = $urandom;
      place_frame(it);
      send_item(it);
    end
    s_tvalid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
